/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk and gated by reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold on every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Implication: when cond holds, prop holds in the next cycle.
`define ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

/* sv/m5ema_pkg.sv */
// ----------------------------------------------------------------------------
// m5ema_pkg
// Shared widths, register indexes and types of the median/EMA window checker.
// ----------------------------------------------------------------------------
package m5ema_pkg;

	// Sample format and smoothing strength.
	localparam int SAMPLE_BITS  = 12;
	localparam int SMOOTH_SHIFT = 4;
	localparam int NUM_SAMPLES  = 5;

	// Stream widths, padded to whole bytes.
	localparam int IN_TDATA_BITS  = ((NUM_SAMPLES * SAMPLE_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;

	// Configuration register indexes.
	localparam int CFG_INDEX_BITS = 2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_LOWER_LIMIT = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_UPPER_LIMIT = 2'd1;

	// Queue between the median front and the averaging back.
	localparam int QUEUE_DEPTH    = 2;
	localparam int QUEUE_PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

	typedef logic [SAMPLE_BITS-1:0] sample_t;

	// One configuration write as seen by the back part.
	typedef struct packed {
		logic                      valid;
		logic [CFG_INDEX_BITS-1:0] index;
		sample_t                   data;
	} cfg_wr_t;

endpackage

/* sv/m5ema_front.sv */
// ----------------------------------------------------------------------------
// m5ema_front
// Accepts input items and forms the median of the five samples in one stage.
// ----------------------------------------------------------------------------
module m5ema_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [m5ema_pkg::IN_TDATA_BITS-1:0] in_data,
	output logic                                med_valid,
	input  logic                                med_ready,
	output m5ema_pkg::sample_t                  med_data
);
	import m5ema_pkg::*;

	sample_t smp [NUM_SAMPLES];
	sample_t lo_ab, hi_ab, lo_cd, hi_cd, f_lo, g_hi, median;
	logic    valid_s1;
	sample_t med_s1;
	logic    advance;

	function automatic sample_t smin(input sample_t x, input sample_t y);
		return (x < y) ? x : y;
	endfunction

	function automatic sample_t smax(input sample_t x, input sample_t y);
		return (x < y) ? y : x;
	endfunction

	// Unpack the five samples, first one in the lowest bits.
	always_comb begin
		for (int i = 0; i < NUM_SAMPLES; i++) begin
			smp[i] = in_data[i*SAMPLE_BITS +: SAMPLE_BITS];
		end
	end

	// Median of five: the two pair extremes bracket the median, then a median of three.
	always_comb begin
		lo_ab  = smin(smp[0], smp[1]);
		hi_ab  = smax(smp[0], smp[1]);
		lo_cd  = smin(smp[2], smp[3]);
		hi_cd  = smax(smp[2], smp[3]);
		f_lo   = smax(lo_ab, lo_cd);
		g_hi   = smin(hi_ab, hi_cd);
		median = smax(smin(f_lo, g_hi), smin(smax(f_lo, g_hi), smp[4]));
	end

	// The stage moves whenever it is empty or the queue takes its item.
	assign advance  = !valid_s1 || med_ready;
	assign in_ready = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			med_s1 <= median;
		end
	end

	assign med_valid = valid_s1;
	assign med_data  = med_s1;

endmodule

/* sv/m5ema_queue.sv */
// ----------------------------------------------------------------------------
// m5ema_queue
// Small register queue of medians between the front and the back part.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module m5ema_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_ready,
	input  m5ema_pkg::sample_t push_data,
	output logic               pop_valid,
	input  logic               pop_ready,
	output m5ema_pkg::sample_t pop_data
);
	import m5ema_pkg::*;

	sample_t                   slot_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [QUEUE_CNT_BITS-1:0] count_q;
	logic                      push, pop;

	assign push_ready = (count_q != QUEUE_CNT_BITS'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = slot_q[rd_ptr_q];

	function automatic logic [QUEUE_PTR_BITS-1:0] ptr_inc(input logic [QUEUE_PTR_BITS-1:0] p);
		return (p == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Payload slots.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	`ASSERT_ALWAYS(a_count_bound, count_q <= QUEUE_CNT_BITS'(QUEUE_DEPTH), "queue count over depth")
	`ASSERT_NEXT(a_count_up, push && !pop, count_q == $past(count_q) + 1'b1, "count missed a push")
	`ASSERT_NEXT(a_count_dn, pop && !push, count_q == $past(count_q) - 1'b1, "count missed a pop")

endmodule

/* sv/m5ema_back.sv */
// ----------------------------------------------------------------------------
// m5ema_back
// Updates the moving average from each median and checks it against the window.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module m5ema_back (
	input  logic               clk,
	input  logic               arst_n,
	input  m5ema_pkg::cfg_wr_t cfg_wr,
	input  logic               med_valid,
	output logic               med_ready,
	input  m5ema_pkg::sample_t med_data,
	output logic               out_valid,
	input  logic               out_ready,
	output m5ema_pkg::sample_t out_smoothed,
	output logic               out_in_window
);
	import m5ema_pkg::*;

	sample_t                lower_q, upper_q;
	sample_t                avg_q;
	logic                   primed_q;
	logic                   out_valid_q;
	sample_t                smoothed_q;
	logic                   in_window_q;
	logic                   take;
	logic signed [SAMPLE_BITS:0] diff, step;
	sample_t                avg_next;

	// Limit registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q <= '0;
			upper_q <= '1;
		end else if (cfg_wr.valid) begin
			unique case (cfg_wr.index)
				REG_LOWER_LIMIT: lower_q <= cfg_wr.data;
				REG_UPPER_LIMIT: upper_q <= cfg_wr.data;
				default: ;
			endcase
		end
	end

	// A median is taken when the output register is free or being emptied.
	assign take      = med_valid && (!out_valid_q || out_ready);
	assign med_ready = !out_valid_q || out_ready;

	// Signed difference, floored shift, and the new average.
	always_comb begin
		diff = $signed({1'b0, med_data}) - $signed({1'b0, avg_q});
		step = diff >>> SMOOTH_SHIFT;
		if (primed_q) begin
			avg_next = SAMPLE_BITS'($signed({1'b0, avg_q}) + step);
		end else begin
			avg_next = med_data;
		end
	end

	// Average state and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_q       <= '0;
			primed_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				avg_q    <= avg_next;
				primed_q <= 1'b1;
			end
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (take) begin
			smoothed_q  <= avg_next;
			in_window_q <= (avg_next > lower_q) && (avg_next < upper_q);
		end
	end

	assign out_valid     = out_valid_q;
	assign out_smoothed  = smoothed_q;
	assign out_in_window = in_window_q;

	`ASSERT_NEXT(a_prime_on_take, !primed_q && !take, !primed_q, "primed set without an item")
	`ASSERT_NEXT(a_avg_tracks, take, avg_q == smoothed_q, "average and result disagree")

endmodule

/* sv/median5_ema_window_check.sv */
// ----------------------------------------------------------------------------
// median5_ema_window_check
// Median of five ADC samples, exponential moving average, window check.
//
//   channel  dir  handshake            payload
//   s_*      in   s_tvalid/s_tready    s_tdata: sample_a..sample_e
//   m_*      out  m_tvalid/m_tready    m_tdata: smoothed, m_tuser: in_window
//   cfg_*    in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item per cycle is sustained while m_tready stays high; an accepted item
// is registered in turn in the median stage, the queue and the average/output
// register. The median network and the add-shift update are combinational.
// A two-entry queue lets the front keep accepting, until it fills, while the output is stalled.
// Reset clears the average, the primed flag and sets the limits to 0 and 4095.
// Configuration writes are always taken (cfg_ready is high).
// ----------------------------------------------------------------------------
module median5_ema_window_check (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// sample_a [11:0], sample_b [23:12], sample_c [35:24], sample_d [47:36],
	// sample_e [59:48], zero pad above
	input  logic [m5ema_pkg::IN_TDATA_BITS-1:0]  s_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// smoothed [11:0], zero pad above
	output logic [m5ema_pkg::OUT_TDATA_BITS-1:0] m_tdata,
	// in_window [0]
	output logic                                 m_tuser,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [m5ema_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [m5ema_pkg::SAMPLE_BITS-1:0]    cfg_data
);
	import m5ema_pkg::*;

	logic    fr_valid, fr_ready;
	sample_t fr_data;
	logic    q_valid, q_ready;
	sample_t q_data;
	sample_t smoothed;
	cfg_wr_t cfg_wr;

	assign cfg_ready     = 1'b1;
	assign cfg_wr.valid  = cfg_valid;
	assign cfg_wr.index  = cfg_index;
	assign cfg_wr.data   = cfg_data;

	// Front: accept and take the median.
	m5ema_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_data   (s_tdata),
		.med_valid (fr_valid),
		.med_ready (fr_ready),
		.med_data  (fr_data)
	);

	// Queue between front and back.
	m5ema_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fr_valid),
		.push_ready (fr_ready),
		.push_data  (fr_data),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_data   (q_data)
	);

	// Back: average update, window check and output register.
	m5ema_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr        (cfg_wr),
		.med_valid     (q_valid),
		.med_ready     (q_ready),
		.med_data      (q_data),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_smoothed  (smoothed),
		.out_in_window (m_tuser)
	);

	assign m_tdata = OUT_TDATA_BITS'(smoothed);

endmodule

/* dv/tb_median5_ema_window_check.sv */
// ----------------------------------------------------------------------------
// tb_median5_ema_window_check
// Self-checking bench for the median-of-five / moving-average window checker.
//
// Sample groups are queued by the stimulus process and offered by a driver on
// the falling clock edge. A monitor on the rising edge predicts the smoothed
// value and the window flag of every accepted group and compares each output
// item, in order, with the prediction. Sender idling and receiver stalls
// change from phase to phase, and one phase holds the output off long enough
// to back the block up. Limit registers change only while the block is idle.
// ----------------------------------------------------------------------------
module tb_median5_ema_window_check;
	import m5ema_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 300;
	localparam int PAD_IN_BITS   = IN_TDATA_BITS - NUM_SAMPLES * SAMPLE_BITS;
	localparam int PAD_OUT_BITS  = OUT_TDATA_BITS - SAMPLE_BITS;

	// Register indexes that the block does not decode.
	localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_B = 2'd3;

	typedef logic [NUM_SAMPLES-1:0][SAMPLE_BITS-1:0] group_t;

	typedef struct {
		sample_t smoothed;
		logic    in_window;
	} reading_t;

	// Block ports.
	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      s_tvalid = 1'b0;
	logic                      s_tready;
	logic [IN_TDATA_BITS-1:0]  s_tdata = '0;
	logic                      m_tvalid;
	logic                      m_tready = 1'b0;
	logic [OUT_TDATA_BITS-1:0] m_tdata;
	logic                      m_tuser;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	sample_t                   cfg_data = '0;

	// Stimulus and checking state.
	group_t   sample_groups[$];
	reading_t expected_readings[$];
	reading_t head_reading;
	logic     item_taken = 1'b0;
	int       send_idle_pct = 0;
	int       recv_stall_pct = 0;
	int       holds_asked = 0;
	int       holds_served = 0;
	int       hold_left = 0;
	int       mismatches = 0;
	int       cycle_count = 0;
	int       drift_center = 2048;

	// Shadow of the block state.
	sample_t  avg_model = '0;
	logic     primed_model = 1'b0;
	sample_t  lower_model = '0;
	sample_t  upper_model = '1;
	sample_t  latest_median;

	median5_ema_window_check dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Free-running clock, period 10.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The sample of rank two among five: fewer than three below it, at least
	// three at or below it.
	function automatic sample_t mid_of_five(input group_t g);
		int i;
		int j;
		int below;
		int same;
		sample_t pick;
		pick = '0;
		for (i = 0; i < NUM_SAMPLES; i++) begin
			below = 0;
			same = 0;
			for (j = 0; j < NUM_SAMPLES; j++) begin
				if (g[j] < g[i])
					below++;
				else if (g[j] == g[i])
					same++;
			end
			if (below <= 2 && below + same > 2)
				pick = g[i];
		end
		return pick;
	endfunction

	// Moving-average step; the arithmetic shift of a signed int rounds down.
	function automatic sample_t ema_next(input sample_t avg, input sample_t target);
		int diff;
		diff = int'(target) - int'(avg);
		return sample_t'(int'(avg) + (diff >>> SMOOTH_SHIFT));
	endfunction

	function automatic sample_t to_sample(input int v);
		if (v < 0)
			return '0;
		if (v > 4095)
			return '1;
		return sample_t'(v);
	endfunction

	function automatic group_t five(input sample_t a, input sample_t b, input sample_t c,
			input sample_t d, input sample_t e);
		group_t g;
		g[0] = a;
		g[1] = b;
		g[2] = c;
		g[3] = d;
		g[4] = e;
		return g;
	endfunction

	// Random group around a drifting level, with outliers, extremes and some
	// fully random groups mixed in.
	function automatic group_t make_group();
		group_t g;
		int k;
		int pick;
		logic whole_uniform;
		if ($urandom_range(99) < 4)
			drift_center = $urandom_range(4095);
		else
			drift_center = to_sample(drift_center + int'($urandom_range(64)) - 32);
		whole_uniform = ($urandom_range(99) < 10);
		for (k = 0; k < NUM_SAMPLES; k++) begin
			pick = $urandom_range(99);
			if (whole_uniform || pick < 12)
				g[k] = sample_t'($urandom_range(4095));
			else if (pick < 20)
				g[k] = pick[0] ? '1 : '0;
			else
				g[k] = to_sample(drift_center + int'($urandom_range(96)) - 48);
		end
		return g;
	endfunction

	// Driver: a group stays offered until it is taken.
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (item_taken)
				void'(sample_groups.pop_front());
			if (s_tvalid && !item_taken) begin
				// Keep offering the same group.
			end else if (sample_groups.size() > (item_taken ? 1 : 0) - (item_taken ? 1 : 0)
					&& sample_groups.size() != 0
					&& $urandom_range(99) >= send_idle_pct) begin
				s_tvalid <= 1'b1;
				s_tdata <= {{PAD_IN_BITS{1'b0}}, sample_groups[0]};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off whenever one is requested.
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (holds_served != holds_asked) begin
			m_tready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			holds_served <= holds_served + 1;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Monitor: check output items, predict accepted groups, track the limits.
	always @(posedge clk) begin
		if (!arst_n) begin
			item_taken <= 1'b0;
		end else begin
			item_taken <= s_tvalid && s_tready;
			if (m_tvalid && m_tready) begin
				if (expected_readings.size() == 0) begin
					$display("%0t: unexpected output item, expected none, actual smoothed %0d in_window %0b",
						$time, m_tdata, m_tuser);
					mismatches++;
				end else begin
					head_reading = expected_readings.pop_front();
					if (m_tdata !== {{PAD_OUT_BITS{1'b0}}, head_reading.smoothed}) begin
						$display("%0t: smoothed mismatch, expected %0d, actual %0d",
							$time, head_reading.smoothed, m_tdata);
						mismatches++;
					end
					if (m_tuser !== head_reading.in_window) begin
						$display("%0t: in_window mismatch, expected %0b, actual %0b",
							$time, head_reading.in_window, m_tuser);
						mismatches++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				latest_median = mid_of_five(s_tdata[NUM_SAMPLES*SAMPLE_BITS-1:0]);
				avg_model = primed_model ? ema_next(avg_model, latest_median) : latest_median;
				primed_model = 1'b1;
				expected_readings.push_back('{smoothed: avg_model,
					in_window: (avg_model > lower_model) && (avg_model < upper_model)});
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_LOWER_LIMIT: lower_model = cfg_data;
					REG_UPPER_LIMIT: upper_model = cfg_data;
					default: ;
				endcase
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[median5_ema_window_check] ERROR");
			$finish;
		end
	end

	task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx, input sample_t val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_limits(input sample_t lo, input sample_t hi);
		write_register(REG_LOWER_LIMIT, lo);
		write_register(REG_UPPER_LIMIT, hi);
	endtask

	// Wait until every queued group has produced its output item.
	task automatic drain();
		while (sample_groups.size() != 0 || s_tvalid || expected_readings.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_items(input int count, input int idle_pct, input int stall_pct);
		int n;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (n = 0; n < count; n++)
			sample_groups.push_back(make_group());
		drain();
	endtask

	// Hold the average steady with groups at its own level.
	task automatic steady_pair();
		sample_groups.push_back(five(avg_model, avg_model, avg_model, avg_model, avg_model));
		sample_groups.push_back(five(avg_model, avg_model, avg_model, avg_model, avg_model));
		drain();
	endtask

	// Stimulus sequence.
	initial begin
		int lvl;
		int lo;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed groups under the reset limits: priming, rounding of small
		// steps in both directions, full-scale jumps, orderings, duplicates.
		sample_groups.push_back(five(2048, 2048, 2048, 2048, 2048));
		sample_groups.push_back(five(2063, 2063, 2063, 2063, 2063));
		sample_groups.push_back(five(2064, 2064, 2064, 2064, 2064));
		sample_groups.push_back(five(2048, 2048, 2048, 2048, 2048));
		sample_groups.push_back(five(2032, 2032, 2032, 2032, 2032));
		sample_groups.push_back(five(2030, 2030, 2030, 2030, 2030));
		sample_groups.push_back(five(4095, 4095, 4095, 4095, 4095));
		sample_groups.push_back(five(0, 0, 0, 0, 0));
		sample_groups.push_back(five(100, 4000, 50, 3000, 2000));
		sample_groups.push_back(five(0, 0, 4095, 4095, 4095));
		sample_groups.push_back(five(4095, 4095, 0, 0, 0));
		sample_groups.push_back(five(1, 2, 3, 4, 5));
		sample_groups.push_back(five(5, 4, 3, 2, 1));
		sample_groups.push_back(five(7, 7, 9, 7, 1));
		sample_groups.push_back(five(12'hAAA, 12'h555, 12'hFFF, 12'h000, 12'hAAA));
		sample_groups.push_back(five(12'h555, 12'hAAA, 12'h000, 12'hFFF, 12'h555));
		sample_groups.push_back(five(4095, 4095, 4095, 4095, 4095));
		sample_groups.push_back(five(4095, 4095, 4095, 4095, 4095));
		drain();

		// Window edges: average just inside, equal to the lower limit, equal
		// to the upper limit.
		lvl = int'(avg_model);
		set_limits(to_sample(lvl - 1), to_sample(lvl + 1));
		steady_pair();
		set_limits(avg_model, to_sample(lvl + 2));
		steady_pair();
		set_limits(to_sample(lvl - 2), avg_model);
		steady_pair();

		// Wide window, no idling.
		set_limits(1024, 3072);
		run_items(350, 0, 0);

		// Inverted window; writes to undecoded indexes must change nothing.
		set_limits(4095, 0);
		write_register(REG_SPARE_A, 12'h7FF);
		write_register(REG_SPARE_B, 12'h001);
		run_items(100, 83, 0);
		lo = $urandom_range(2000);
		set_limits(sample_t'(lo), sample_t'(lo + int'($urandom_range(2095))));
		run_items(250, 83, 0);

		// Empty window, then a middle window, with a stalling receiver.
		set_limits(0, 1);
		run_items(100, 0, 83);
		set_limits(1500, 2600);
		run_items(300, 0, 83);

		// Top-edge window, then a random one, both sides idling.
		set_limits(4094, 4095);
		run_items(100, 11, 11);
		lo = $urandom_range(4095);
		set_limits(sample_t'(lo), sample_t'($urandom_range(4095)));
		run_items(300, 11, 11);

		// Long output hold-off while the sender keeps offering.
		set_limits(0, 4095);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		for (lo = 0; lo < 150; lo++)
			sample_groups.push_back(make_group());
		holds_asked = holds_asked + 1;
		drain();

		if (mismatches == 0 && expected_readings.size() == 0) begin
			$display("[median5_ema_window_check] OK");
		end else begin
			$display("[median5_ema_window_check] ERROR");
		end
		$finish;
	end

endmodule

/* median5_ema_window_check.f */
+incdir+sv
sv/m5ema_pkg.sv
sv/m5ema_front.sv
sv/m5ema_queue.sv
sv/m5ema_back.sv
sv/median5_ema_window_check.sv
dv/tb_median5_ema_window_check.sv
